// File: rtl/tfn_pkg.sv
// Package for the triangle unit face normal block.
// Holds the coordinate format, the item and result structs and the queue entry type.
// No dependencies.
`default_nettype none

package tfn_pkg;

  // Coordinate format
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // Normalised magnitude width ahead of the square root
  localparam int MAG_BITS    = 30;
  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One input item: three vertices
  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
  } in_t;

  // One result item
  typedef struct packed {
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    logic   degenerate;
  } out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [2:0][MAG_BITS-1:0]    mag;
    logic [2:0]                  neg;
    logic [2:0][COORD_WIDTH-1:0] v0;
    logic                        degen;
  } work_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic vld;
  } qstat_t;

endpackage

`default_nettype wire

// File: rtl/tfn_front.sv
// Front end: edges, cross-product terms, magnitude, bit length and normalising shift.
// Uses tfn_pkg. Five register stages, all held while en is low.
`default_nettype none

module tfn_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          take,
  input  wire tfn_pkg::in_t  item,
  output logic               vld,
  output tfn_pkg::work_t     work
);

  localparam int CW = tfn_pkg::COORD_WIDTH;
  localparam int MB = tfn_pkg::MAG_BITS;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int LW = $clog2(NW + 1);

  // bit length of a magnitude word
  function automatic logic [LW-1:0] bitlen(input logic [NW-1:0] v);
    logic [LW-1:0] n;
    n = '0;
    for (int k = 0; k < NW; k++) begin
      if (v[k]) n = LW'(k + 1);
    end
    return n;
  endfunction

  logic signed [CW-1:0] c0 [3];
  logic signed [CW-1:0] c1 [3];
  logic signed [CW-1:0] c2 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  logic                 s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  logic signed [EW-1:0] s1_e1 [3];
  logic signed [EW-1:0] s1_e2 [3];
  logic [CW-1:0]        s1_v0 [3];
  logic signed [PW-1:0] s2_p [6];
  logic [CW-1:0]        s2_v0 [3];
  logic [NW-1:0]        s3_mag [3];
  logic [2:0]           s3_neg;
  logic [CW-1:0]        s3_v0 [3];
  logic [NW-1:0]        s4_mag [3];
  logic [2:0]           s4_neg;
  logic [CW-1:0]        s4_v0 [3];
  logic [LW-1:0]        s4_len;
  tfn_pkg::work_t       s5_work;

  logic signed [NW-1:0] n_val [3];
  logic [NW-1:0]        n_mag [3];
  logic [NW+MB-1:0]     shifted [3];

  // edge vectors
  always_comb begin
    c0[0] = item.v0_x; c0[1] = item.v0_y; c0[2] = item.v0_z;
    c1[0] = item.v1_x; c1[1] = item.v1_y; c1[2] = item.v1_z;
    c2[0] = item.v2_x; c2[1] = item.v2_y; c2[2] = item.v2_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed({c1[i][CW-1], c1[i]}) - $signed({c0[i][CW-1], c0[i]});
      e2[i] = $signed({c2[i][CW-1], c2[i]}) - $signed({c0[i][CW-1], c0[i]});
    end
  end

  // cross-product terms to signed magnitude
  always_comb begin
    n_val[0] = $signed({s2_p[0][PW-1], s2_p[0]}) - $signed({s2_p[1][PW-1], s2_p[1]});
    n_val[1] = $signed({s2_p[2][PW-1], s2_p[2]}) - $signed({s2_p[3][PW-1], s2_p[3]});
    n_val[2] = $signed({s2_p[4][PW-1], s2_p[4]}) - $signed({s2_p[5][PW-1], s2_p[5]});
    for (int i = 0; i < 3; i++) begin
      n_mag[i] = n_val[i][NW-1] ? NW'(-n_val[i]) : NW'(n_val[i]);
    end
  end

  // normalising shift: magnitude moved so the largest has MB bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {s4_mag[i], {MB{1'b0}}} >> s4_len;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= take;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1[i] <= e1[i];
        s1_e2[i] <= e2[i];
        s1_v0[i] <= c0[i];
        s2_v0[i] <= s1_v0[i];
        s3_mag[i] <= n_mag[i];
        s3_v0[i] <= s2_v0[i];
        s4_mag[i] <= s3_mag[i];
        s4_v0[i] <= s3_v0[i];
        s5_work.mag[i] <= shifted[i][MB-1:0];
        s5_work.v0[i] <= s4_v0[i];
      end
      s2_p[0] <= s1_e1[1] * s1_e2[2];
      s2_p[1] <= s1_e1[2] * s1_e2[1];
      s2_p[2] <= s1_e1[2] * s1_e2[0];
      s2_p[3] <= s1_e1[0] * s1_e2[2];
      s2_p[4] <= s1_e1[0] * s1_e2[1];
      s2_p[5] <= s1_e1[1] * s1_e2[0];
      s3_neg <= {n_val[2][NW-1], n_val[1][NW-1], n_val[0][NW-1]};
      s4_neg <= s3_neg;
      s4_len <= bitlen(s3_mag[0] | s3_mag[1] | s3_mag[2]);
      s5_work.neg <= s4_neg;
      s5_work.degen <= (s4_len == '0);
    end
  end

  assign vld  = s5_vld;
  assign work = s5_work;

endmodule

`default_nettype wire

// File: rtl/tfn_queue.sv
// Short queue between front and back.
// Uses tfn_pkg (work_t, qstat_t, QUEUE_DEPTH). The back pops whenever an entry is present.
`default_nettype none

module tfn_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tfn_pkg::work_t  wdata,
  output tfn_pkg::qstat_t      stat,
  output tfn_pkg::work_t       rdata
);

  localparam int D  = tfn_pkg::QUEUE_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CNW = $clog2(D + 1);

  tfn_pkg::work_t mem [D];
  logic [AW-1:0]  wptr, rptr;
  logic [CNW-1:0] count;
  logic           pop;

  assign pop = (count != '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(D - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(D - 1)) ? '0 : rptr + 1'b1;
      count <= count + CNW'(push) - CNW'(pop);
    end
  end

  assign stat.full = (count == CNW'(D));
  assign stat.vld  = pop;
  assign rdata     = mem[rptr];

endmodule

`default_nettype wire

// File: rtl/tfn_back.sv
// Back end: squares, sum, pipelined square root, pipelined divide, sign and saturating add.
// Uses tfn_pkg. Never stalls: one item may enter each cycle.
`default_nettype none

module tfn_back #(
  parameter int FRAC_BITS = tfn_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire tfn_pkg::work_t  work,
  output logic                 done,
  output tfn_pkg::out_t        result
);

  localparam int CW  = tfn_pkg::COORD_WIDTH;
  localparam int MB  = tfn_pkg::MAG_BITS;
  localparam int SQW = 2 * MB;          // one square
  localparam int SW  = SQW + 2;         // sum of three squares
  localparam int RT  = SW / 2;          // root bits
  localparam int RMW = RT + 3;          // root remainder
  localparam int DQ  = FRAC_BITS + 1;   // quotient bits
  localparam int NB  = MB + FRAC_BITS + 1;
  localparam int DRW = RT;              // divide remainder, below the root
  localparam int UW  = DQ + 1;          // signed unit component

  // squares
  logic           b1_vld;
  logic [SQW-1:0] b1_sq [3];
  tfn_pkg::work_t b1_w;

  // root stages
  logic           rt_vld [RT+1];
  logic [RMW-1:0] rt_rem [RT+1];
  logic [RT-1:0]  rt_q   [RT+1];
  logic [SW-1:0]  rt_s   [RT+1];
  tfn_pkg::work_t rt_w   [RT+1];

  // divide stages, three lanes
  logic           dv_vld [DQ+1];
  logic [DRW-1:0] dv_rem [DQ+1][3];
  logic [DQ-1:0]  dv_lo  [DQ+1][3];
  logic [DQ-1:0]  dv_q   [DQ+1][3];
  logic [RT-1:0]  dv_r   [DQ+1];
  tfn_pkg::work_t dv_w   [DQ+1];

  logic [NB-1:0]  num [3];
  tfn_pkg::out_t  res_next;
  logic           res_vld;
  tfn_pkg::out_t  res;

  // squares of the normalised magnitudes
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) b1_sq[i] <= work.mag[i] * work.mag[i];
    b1_w <= work;
  end

  // sum into the first root stage
  always_ff @(posedge clk) begin
    rt_s[0]   <= SW'(b1_sq[0]) + SW'(b1_sq[1]) + SW'(b1_sq[2]);
    rt_rem[0] <= '0;
    rt_q[0]   <= '0;
    rt_w[0]   <= b1_w;
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < RT; k++) begin : g_root
    logic [RMW-1:0] rn, t;
    always_comb begin
      rn = {rt_rem[k][RMW-3:0], rt_s[k][SW-1:SW-2]};
      t  = {1'b0, rt_q[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rn >= t) begin
        rt_rem[k+1] <= rn - t;
        rt_q[k+1]   <= {rt_q[k][RT-2:0], 1'b1};
      end else begin
        rt_rem[k+1] <= rn;
        rt_q[k+1]   <= {rt_q[k][RT-2:0], 1'b0};
      end
      rt_s[k+1] <= {rt_s[k][SW-3:0], 2'b00};
      rt_w[k+1] <= rt_w[k];
    end
  end

  // rounded numerator and first divide stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NB'({rt_w[RT].mag[i], {FRAC_BITS{1'b0}}}) + NB'(rt_q[RT] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= DRW'(num[i][NB-1:DQ]);
      dv_lo[0][i]  <= num[i][DQ-1:0];
      dv_q[0][i]   <= '0;
    end
    dv_r[0] <= rt_q[RT];
    dv_w[0] <= rt_w[RT];
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < DQ; j++) begin : g_div
    logic [DRW:0] rn [3];
    always_comb begin
      for (int i = 0; i < 3; i++) rn[i] = {dv_rem[j][i], dv_lo[j][i][DQ-1]};
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (rn[i] >= {1'b0, dv_r[j]}) begin
          dv_rem[j+1][i] <= DRW'(rn[i] - {1'b0, dv_r[j]});
          dv_q[j+1][i]   <= {dv_q[j][i][DQ-2:0], 1'b1};
        end else begin
          dv_rem[j+1][i] <= DRW'(rn[i]);
          dv_q[j+1][i]   <= {dv_q[j][i][DQ-2:0], 1'b0};
        end
        dv_lo[j+1][i] <= {dv_lo[j][i][DQ-2:0], 1'b0};
      end
      dv_r[j+1] <= dv_r[j];
      dv_w[j+1] <= dv_w[j];
    end
  end

  // sign, offset by vertex 0 and saturate
  always_comb begin
    logic signed [UW-1:0]   u;
    logic signed [CW+1:0]   s;
    logic [CW-1:0]          o [3];
    for (int i = 0; i < 3; i++) begin
      u = dv_w[DQ].degen ? '0 : $signed({1'b0, dv_q[DQ][i]});
      if (dv_w[DQ].neg[i]) u = -u;
      s = $signed({{2{dv_w[DQ].v0[i][CW-1]}}, dv_w[DQ].v0[i]}) + (CW+2)'(u);
      if (s > $signed({3'b000, {(CW-1){1'b1}}}))
        o[i] = {1'b0, {(CW-1){1'b1}}};
      else if (s < $signed({3'b111, {(CW-1){1'b0}}}))
        o[i] = {1'b1, {(CW-1){1'b0}}};
      else
        o[i] = s[CW-1:0];
    end
    res_next.normal_x   = o[0];
    res_next.normal_y   = o[1];
    res_next.normal_z   = o[2];
    res_next.degenerate = dv_w[DQ].degen;
  end

  always_ff @(posedge clk) res <= res_next;

  // valid chain through every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld  <= 1'b0;
      res_vld <= 1'b0;
      for (int k = 0; k <= RT; k++) rt_vld[k] <= 1'b0;
      for (int j = 0; j <= DQ; j++) dv_vld[j] <= 1'b0;
    end else begin
      b1_vld    <= in_vld;
      rt_vld[0] <= b1_vld;
      for (int k = 0; k < RT; k++) rt_vld[k+1] <= rt_vld[k];
      dv_vld[0] <= rt_vld[RT];
      for (int j = 0; j < DQ; j++) dv_vld[j+1] <= dv_vld[j];
      res_vld   <= dv_vld[DQ];
    end
  end

  assign done   = res_vld;
  assign result = res;

endmodule

`default_nettype wire

// File: rtl/triangle_unit_face_normal.sv
// Unit face normal of a triangle, offset by vertex 0, Q16.16 by default.
// Path: the front stages and the queue, then the back stages (squares, sum, root, divide, output register).
// Throughput: one item per cycle while busy is low; set by the fully pipelined root and divide stages.
// The result strobe done lasts one cycle; the receiver cannot stall, so busy stays low.
// Reset (rst, synchronous, active high) empties all stages and the queue.
`default_nettype none

module triangle_unit_face_normal #(
  parameter int FRAC_BITS = tfn_pkg::FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tfn_pkg::in_t  item,
  output logic               done,
  output tfn_pkg::out_t      result
);

  localparam int BACK_LAT = 35 + FRAC_BITS + 1;

  logic            f_vld;
  tfn_pkg::work_t  f_work;
  tfn_pkg::qstat_t q_stat;
  tfn_pkg::work_t  q_work;
  logic            take;

  assign busy = q_stat.full;
  assign take = start && !busy;

  // front: classify and normalise
  tfn_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (!q_stat.full),
    .take (take),
    .item (item),
    .vld  (f_vld),
    .work (f_work)
  );

  // decoupling queue
  tfn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_vld && !q_stat.full),
    .wdata (f_work),
    .stat  (q_stat),
    .rdata (q_work)
  );

  // back: root, divide, offset
  tfn_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .in_vld (q_stat.vld),
    .work   (q_work),
    .done   (done),
    .result (result)
  );

  // the back drains every cycle, so the queue never fills
  a_never_full: assert property (@(posedge clk) disable iff (rst) !q_stat.full)
    else $error("queue filled");

  // every item leaving the queue comes out after the fixed back latency
  a_back_lat: assert property (@(posedge clk) disable iff (rst)
    q_stat.vld |-> ##BACK_LAT done)
    else $error("result missing after back latency");

  // a degenerate item leaving the queue carries all-zero magnitudes
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (q_stat.vld && q_work.degen) |-> (q_work.mag == '0))
    else $error("degenerate item with nonzero magnitude");

endmodule

`default_nettype wire
